// ===== rtl/usps_pkg.sv =====
package usps_pkg;

	localparam int unsigned MAX_PATH_W   = 10;
	localparam int unsigned COUNT_W      = 11;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAX_PATH_W-1:0] MAX_PATH_RESET = 10'd512;
	localparam logic [COUNT_W-1:0]    COUNT_SAT      = 11'd2047;

	localparam logic [7:0]  LEAD2_MIN  = 8'hc2;
	localparam logic [7:0]  LEAD4_MAX  = 8'hf4;
	localparam logic [20:0] MIN3_VALUE = 21'h000800;
	localparam logic [20:0] MIN4_VALUE = 21'h010000;
	localparam logic [20:0] SURR_LOW   = 21'h00d800;
	localparam logic [20:0] SURR_HIGH  = 21'h00dfff;
	localparam logic [20:0] CP_MAX     = 21'h10ffff;

	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		U8_ASCII,
		U8_CONT,
		U8_LEAD2,
		U8_LEAD3,
		U8_LEAD4,
		U8_BAD
	} u8_class_t;

	// One classified input item as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] lower;
		logic [4:0] lead_bits;
		u8_class_t  u8_class;
		logic       is_slash;
		logic       is_dot;
		logic       is_space;
		logic       is_illegal;
		logic       has;
		logic       last;
	} item_t;

endpackage

// ===== rtl/utf8_path_sanitizer_core.sv =====
// A verdict appears on path_ok with empty low after the item marked last is written into
// the queue and then taken by the back-end step into the result register, when the queue
// is empty and the result slot is free.
// Throughput: one item per cycle in the back end; a final item waits on a full result slot.
// Reset: arst_n is asynchronous and active low; it empties the queue and the result slot,
// clears all per-path state and loads max_path_bytes with 512.
module utf8_path_sanitizer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      path_byte,
	input  logic                            has_byte,
	input  logic                            last,
	output logic                            empty,
	input  logic                            pop,
	output logic                            path_ok,
	input  logic                            cfg_we,
	input  logic [usps_pkg::MAX_PATH_W-1:0] cfg_data
);
	import usps_pkg::*;

	// The front end classifies each byte (character tests, UTF-8 byte class and lead
	// payload, lower-case form) and writes the classified item into a short queue.
	// The back end drains the queue one item a cycle, unless a final item waits for the
	// result register, walks the UTF-8 decoder and the component tracker, and leaves
	// the verdict in a one-entry result register. Items that do not end a path are
	// never held back by a waiting verdict, so only a verdict competes for the result register.

	item_t front_item;
	item_t head_item;
	logic  queue_wr;
	logic  queue_full;
	logic  queue_not_empty;
	logic  queue_rd;

	assign full = queue_full;

	usps_front u_front (
		.push       (push),
		.path_byte  (path_byte),
		.has_byte   (has_byte),
		.last       (last),
		.queue_full (queue_full),
		.queue_wr   (queue_wr),
		.item       (front_item)
	);

	// The queue lets a transfer on the input side proceed while a verdict waits.
	usps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (queue_wr),
		.wr_item   (front_item),
		.rd        (queue_rd),
		.rd_item   (head_item),
		.full      (queue_full),
		.not_empty (queue_not_empty)
	);

	usps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.item       (head_item),
		.item_valid (queue_not_empty),
		.item_take  (queue_rd),
		.pop        (pop),
		.empty      (empty),
		.path_ok    (path_ok)
	);

endmodule

// ===== rtl/usps_front.sv =====
module usps_front (
	input  logic          push,
	input  logic [7:0]    path_byte,
	input  logic          has_byte,
	input  logic          last,
	input  logic          queue_full,
	output logic          queue_wr,
	output usps_pkg::item_t item
);
	import usps_pkg::*;

	assign queue_wr = push && !queue_full;

	always_comb begin
		item            = '0;
		item.data       = path_byte;
		item.has        = has_byte;
		item.last       = last;
		item.is_slash   = (path_byte == CH_SLASH);
		item.is_dot     = (path_byte == CH_DOT);
		item.is_space   = (path_byte == CH_SPACE);
		item.is_illegal = (path_byte == 8'h5c) || (path_byte == 8'h3a) || (path_byte == 8'h00);
		item.lower      = (path_byte inside {[8'h41:8'h5a]}) ? path_byte + 8'd32 : path_byte;
		item.lead_bits  = 5'd0;
		if (path_byte inside {[8'h00:8'h7f]}) begin
			item.u8_class = U8_ASCII;
		end else if (path_byte inside {[8'h80:8'hbf]}) begin
			item.u8_class = U8_CONT;
		end else if (path_byte inside {[LEAD2_MIN:8'hdf]}) begin
			item.u8_class  = U8_LEAD2;
			item.lead_bits = path_byte[4:0];
		end else if (path_byte inside {[8'he0:8'hef]}) begin
			item.u8_class  = U8_LEAD3;
			item.lead_bits = {1'b0, path_byte[3:0]};
		end else if (path_byte inside {[8'hf0:LEAD4_MAX]}) begin
			item.u8_class  = U8_LEAD4;
			item.lead_bits = {2'b00, path_byte[2:0]};
		end else begin
			item.u8_class = U8_BAD;
		end
	end

endmodule

// ===== rtl/usps_queue.sv =====
module usps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  usps_pkg::item_t wr_item,
	input  logic            rd,
	output usps_pkg::item_t rd_item,
	output logic            full,
	output logic            not_empty
);
	import usps_pkg::*;

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_wr;
	logic                   do_rd;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/usps_back.sv =====
module usps_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [usps_pkg::MAX_PATH_W-1:0] cfg_data,
	input  usps_pkg::item_t                 item,
	input  logic                            item_valid,
	output logic                            item_take,
	input  logic                            pop,
	output logic                            empty,
	output logic                            path_ok
);
	import usps_pkg::*;

	logic [MAX_PATH_W-1:0] max_path_q;
	logic [COUNT_W-1:0]    byte_count_q;
	logic [1:0]            cont_left_q;
	logic [2:0]            seq_len_q;
	logic [20:0]           code_point_q;
	logic [2:0]            seg_len_q;
	logic [2:0]            stem_len_q;
	logic                  dot_seen_q;
	logic [3:0][7:0]       stem_q;
	logic [7:0]            prev_q;
	logic                  failed_q;
	logic                  out_valid_q;
	logic                  out_ok_q;

	logic [COUNT_W-1:0] cnt_d;
	logic [1:0]         cl_d;
	logic [2:0]         sl_d;
	logic [20:0]        cp_d;
	logic [2:0]         seg_d;
	logic [2:0]         stl_d;
	logic               dot_d;
	logic [3:0][7:0]    stem_d;
	logic [7:0]         prev_d;
	logic               fail_d;

	function automatic logic component_bad(input logic [2:0] seg, input logic [7:0] prev,
		input logic [2:0] stl, input logic [3:0][7:0] sc);
		logic res;
		logic [23:0] s3;
		s3  = {sc[0], sc[1], sc[2]};
		res = (seg == 3'd0) || (prev == CH_DOT) || (prev == CH_SPACE);
		if (stl == 3'd3) begin
			res = res || (s3 == "con") || (s3 == "prn") || (s3 == "aux") || (s3 == "nul");
		end else if (stl == 3'd4) begin
			res = res || (((s3 == "com") || (s3 == "lpt")) &&
				(sc[3] >= "1") && (sc[3] <= "9"));
		end
		return res;
	endfunction

	// A verdict needs the output slot; other items never wait for it.
	assign item_take = item_valid && (!item.last || !out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign path_ok   = out_ok_q;

	always_comb begin
		cnt_d  = byte_count_q;
		cl_d   = cont_left_q;
		sl_d   = seq_len_q;
		cp_d   = code_point_q;
		seg_d  = seg_len_q;
		stl_d  = stem_len_q;
		dot_d  = dot_seen_q;
		stem_d = stem_q;
		prev_d = prev_q;
		fail_d = failed_q;
		if (item.has) begin
			if ((byte_count_q == '0) && item.is_slash) begin
				fail_d = 1'b1;
			end
			if (item.is_illegal) begin
				fail_d = 1'b1;
			end
			if (cont_left_q != 2'd0) begin
				if (item.u8_class != U8_CONT) begin
					fail_d = 1'b1;
					cl_d   = 2'd0;
				end else begin
					cp_d = {code_point_q[14:0], item.data[5:0]};
					cl_d = cont_left_q - 2'd1;
					if ((cl_d == 2'd0) &&
						(((seq_len_q == 3'd3) && (cp_d < MIN3_VALUE)) ||
						((seq_len_q == 3'd4) && (cp_d < MIN4_VALUE)) ||
						((cp_d >= SURR_LOW) && (cp_d <= SURR_HIGH)) ||
						(cp_d > CP_MAX))) begin
						fail_d = 1'b1;
					end
				end
			end else begin
				case (item.u8_class)
					U8_ASCII: begin
						sl_d = 3'd1;
					end
					U8_LEAD2: begin
						sl_d = 3'd2;
						cp_d = {16'd0, item.lead_bits};
						cl_d = 2'd1;
					end
					U8_LEAD3: begin
						sl_d = 3'd3;
						cp_d = {16'd0, item.lead_bits};
						cl_d = 2'd2;
					end
					U8_LEAD4: begin
						sl_d = 3'd4;
						cp_d = {16'd0, item.lead_bits};
						cl_d = 2'd3;
					end
					default: begin
						fail_d = 1'b1;
					end
				endcase
			end
			if (item.is_slash) begin
				if (component_bad(seg_len_q, prev_q, stem_len_q, stem_q)) begin
					fail_d = 1'b1;
				end
				seg_d  = 3'd0;
				stl_d  = 3'd0;
				dot_d  = 1'b0;
				stem_d = '0;
			end else begin
				if (seg_len_q < 3'd7) begin
					seg_d = seg_len_q + 3'd1;
				end
				if (!dot_seen_q) begin
					if (item.is_dot) begin
						dot_d = 1'b1;
					end else begin
						if (stem_len_q < 3'd4) begin
							stem_d[stem_len_q[1:0]] = item.lower;
						end
						if (stem_len_q < 3'd5) begin
							stl_d = stem_len_q + 3'd1;
						end
					end
				end
			end
			prev_d = item.data;
			if (byte_count_q < COUNT_SAT) begin
				cnt_d = byte_count_q + 1'b1;
			end
		end
		if (item.last) begin
			if ((cnt_d == '0) || (cnt_d > {1'b0, max_path_q}) || (cl_d != 2'd0)) begin
				fail_d = 1'b1;
			end
			// A closing slash has already ended the last component.
			if (!((cnt_d != '0) && (prev_d == CH_SLASH)) &&
				component_bad(seg_d, prev_d, stl_d, stem_d)) begin
				fail_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_q   <= MAX_PATH_RESET;
			byte_count_q <= '0;
			cont_left_q  <= '0;
			seq_len_q    <= '0;
			code_point_q <= '0;
			seg_len_q    <= '0;
			stem_len_q   <= '0;
			dot_seen_q   <= 1'b0;
			stem_q       <= '0;
			prev_q       <= '0;
			failed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_ok_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_path_q <= cfg_data;
			end
			if (item_take && item.last) begin
				byte_count_q <= '0;
				cont_left_q  <= '0;
				seq_len_q    <= '0;
				code_point_q <= '0;
				seg_len_q    <= '0;
				stem_len_q   <= '0;
				dot_seen_q   <= 1'b0;
				stem_q       <= '0;
				prev_q       <= '0;
				failed_q     <= 1'b0;
				out_valid_q  <= 1'b1;
				out_ok_q     <= !fail_d;
			end else begin
				if (item_take) begin
					byte_count_q <= cnt_d;
					cont_left_q  <= cl_d;
					seq_len_q    <= sl_d;
					code_point_q <= cp_d;
					seg_len_q    <= seg_d;
					stem_len_q   <= stl_d;
					dot_seen_q   <= dot_d;
					stem_q       <= stem_d;
					prev_q       <= prev_d;
					failed_q     <= fail_d;
				end
				if (pop) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/usps_checker.sv =====
module usps_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic last,
	input logic empty,
	input logic pop,
	input logic path_ok
);
	import usps_pkg::*;

	localparam int unsigned PEND_MAX = QUEUE_DEPTH + 1;
	localparam int unsigned PEND_W   = $clog2(PEND_MAX + 2);

	// Verdicts owed: paths whose final item was transferred, less verdicts taken.
	logic [PEND_W-1:0] pending_q;
	logic              in_end;
	logic              out_xfer;

	assign in_end   = push && !full && last;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_end && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_end) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(path_ok)))
		else $error("waiting verdict changed or vanished");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pending_q != '0))
		else $error("verdict shown with no finished path");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_W'(PEND_MAX))
		else $error("more finished paths held than the queue and result slot allow");

	a_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && (pending_q != '0) && !push) |=> (!empty || (pending_q != '0)))
		else $error("owed verdict lost");

endmodule

bind utf8_path_sanitizer_core usps_checker u_usps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.last    (last),
	.empty   (empty),
	.pop     (pop),
	.path_ok (path_ok)
);
